@@ hdl/ir_key_mapper_with_learning_macros.svh @@
// assertion helpers used by the checker in ikm_checker.sv
// all expect a clock named i_clk; the first two also expect an active-low reset named i_rst_n in scope
`ifndef IR_KEY_MAPPER_WITH_LEARNING_MACROS_SVH
`define IR_KEY_MAPPER_WITH_LEARNING_MACROS_SVH

// same-cycle implication, off while in reset
`define IKM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ikm assertion failed");

// next-cycle implication, off while in reset
`define IKM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ikm assertion failed");

// next-cycle implication that also holds across reset
`define IKM_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ikm assertion failed");

`endif

@@ hdl/ikm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ikm_pkg;

    localparam int CODE_W  = 64;
    localparam int KIND_W  = 4;
    localparam int ARG_W   = 3;
    localparam int HOLD_W  = 10;
    localparam int GUARD_W = 11;
    localparam int FLAGS_W = 8;
    localparam int STATE_W = 4;

    localparam int NUM_KEYS_DEF = 8;
    localparam int KEY_STANDBY  = 6;
    localparam int KEY_POWEROFF = 7;

    localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(150);
    localparam logic [HOLD_W-1:0]  GUARD_RESET = HOLD_W'(400);
    localparam logic [GUARD_W-1:0] GUARD_MAX   = '1;
    localparam logic [CODE_W-1:0]  IGNORED_CODE = 64'h0000_0000_FFFF_FFFF;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_FRAME     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_TICK      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LEARN_ONE = 4'd2;
    localparam logic [KIND_W-1:0] KIND_LEARN_ALL = 4'd3;
    localparam logic [KIND_W-1:0] KIND_CANCEL    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SHIELD    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_CONSUME   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_READ      = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CLR_LAST  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_CLR_ERR   = 4'd9;

    // consume argument codes
    localparam logic [ARG_W-1:0] ARG_STANDBY  = 3'd0;
    localparam logic [ARG_W-1:0] ARG_POWEROFF = 3'd1;

    // configuration register indexes
    localparam logic REG_HOLD  = 1'b0;
    localparam logic REG_GUARD = 1'b1;

    typedef logic [CODE_W-1:0] t_code;

    // fixed profile: up, down, left, right, enter, esc, standby, poweroff
    localparam t_code PRESET_CODES [8] = '{
        64'h00FF629D, 64'h00FFA857, 64'h00FF22DD, 64'h00FFC23D,
        64'h00FF02FD, 64'h00FFE01F, 64'h00FFE21D, 64'h00FFA25D
    };

    function automatic t_code preset_code(input int k);
        t_code c;
        c = '0;
        if (k >= 0 && k < 8) begin
            c = PRESET_CODES[k];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ikm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// input beat channel
interface ikm_in_if;
    logic                          valid;
    logic                          ready;
    logic [ikm_pkg::KIND_W-1:0]    kind;
    logic [ikm_pkg::ARG_W-1:0]     arg;
    logic [ikm_pkg::CODE_W-1:0]    frame_code;
    logic                          frame_bad;

    modport source (output valid, output kind, output arg, output frame_code,
                    output frame_bad, input ready);
    modport sink   (input valid, input kind, input arg, input frame_code,
                    input frame_bad, output ready);
endinterface

// result beat channel
interface ikm_out_if;
    logic                          valid;
    logic                          ready;
    logic [ikm_pkg::FLAGS_W-1:0]   key_flags;
    logic [ikm_pkg::CODE_W-1:0]    last_code;
    logic [ikm_pkg::STATE_W-1:0]   learn_state;
    logic                          learn_sequential;
    logic                          duplicate_error;
    logic [ikm_pkg::CODE_W-1:0]    code_out;

    modport source (output valid, output key_flags, output last_code,
                    output learn_state, output learn_sequential,
                    output duplicate_error, output code_out, input ready);
    modport sink   (input valid, input key_flags, input last_code,
                    input learn_state, input learn_sequential,
                    input duplicate_error, input code_out, output ready);
endinterface

`default_nettype wire

@@ hdl/ir_key_mapper_with_learning.sv @@
// ir key mapper with learning
// maps decoded remote codes onto NUM_KEYS keys and learns new codes per key.
// i_in: one beat per event (frame, tick, learn one/all, cancel, shield,
//   consume, read code, clear last code, clear error), valid/ready.
// o_out: one result beat per input beat, carrying the state after that event.
// i_cfg_*: write port for hold_ticks (index 0) and pair_guard_ticks (index 1),
//   the user must write it only while no beat is in flight (not enforced).
// the result of a beat is registered and is shown in the cycle after it is accepted.
// throughput: one beat per cycle unless o_out stalls; the whole update
//   (NUM_KEYS 64-bit compares, countdowns, learn bookkeeping) is one level
//   of logic ahead of the state and result registers.
// stall: the result register holds while o_out.ready is low; i_in.ready is
//   high when that register is empty or being drained in the same cycle.
// reset (synchronous, i_rst_n low): key codes return to the preset profile,
//   flags, countdowns, learn state and shield clear, config returns to
//   150 / 400, and the result register empties.
`timescale 1ns / 1ps
`default_nettype none

module ir_key_mapper_with_learning #(
    parameter int NUM_KEYS = ikm_pkg::NUM_KEYS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    ikm_in_if.sink                           i_in,
    ikm_out_if.source                        o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [ikm_pkg::HOLD_W-1:0]  i_cfg_data
);

    // learn phase: 0 idle, k+1 learning key k, NUM_KEYS+1 done
    localparam int PW = $clog2(NUM_KEYS + 2);
    localparam logic [PW-1:0] PH_IDLE = '0;
    localparam logic [PW-1:0] PH_DONE = PW'(NUM_KEYS + 1);
    // keys visible on the flag output
    localparam int FW = (NUM_KEYS < ikm_pkg::FLAGS_W) ? NUM_KEYS : ikm_pkg::FLAGS_W;

    // configuration
    logic [ikm_pkg::HOLD_W-1:0]   r_hold_ticks;
    logic [ikm_pkg::HOLD_W-1:0]   r_guard_ticks;

    // architectural state
    ikm_pkg::t_code               r_key_codes [NUM_KEYS];
    logic [NUM_KEYS-1:0]          r_flag_bits;
    logic [ikm_pkg::HOLD_W-1:0]   r_hold_cnt [NUM_KEYS];
    logic [ikm_pkg::GUARD_W-1:0]  r_guard_cnt;
    ikm_pkg::t_code               r_recent;
    logic [PW-1:0]                r_phase;
    logic                         r_walk_all;
    logic                         r_dup;
    logic                         r_shield;

    ikm_pkg::t_code               n_key_codes [NUM_KEYS];
    logic [NUM_KEYS-1:0]          n_flag_bits;
    logic [ikm_pkg::HOLD_W-1:0]   n_hold_cnt [NUM_KEYS];
    logic [ikm_pkg::GUARD_W-1:0]  n_guard_cnt;
    ikm_pkg::t_code               n_recent;
    logic [PW-1:0]                n_phase;
    logic                         n_walk_all;
    logic                         n_dup;
    logic                         n_shield;

    // result register
    logic                         r_out_valid;
    logic [ikm_pkg::FLAGS_W-1:0]  r_key_flags;
    ikm_pkg::t_code               r_last_code;
    logic [ikm_pkg::STATE_W-1:0]  r_learn_state;
    logic                         r_learn_seq;
    logic                         r_dup_err;
    ikm_pkg::t_code               r_code_out;

    logic                         in_fire;
    logic                         active;
    logic                         n_active;
    logic [PW-1:0]                cur;
    logic [NUM_KEYS-1:0]          hit;
    logic [NUM_KEYS-1:0]          first_hit;
    logic [NUM_KEYS-1:0]          cur_sel;
    logic                         dup_hit;
    logic                         frame_ok;
    ikm_pkg::t_code               code_sel;
    logic [ikm_pkg::FLAGS_W-1:0]  flags_vis;

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks  <= ikm_pkg::HOLD_RESET;
            r_guard_ticks <= ikm_pkg::GUARD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ikm_pkg::REG_HOLD:  r_hold_ticks  <= i_cfg_data;
                ikm_pkg::REG_GUARD: r_guard_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-key match against the stored codes, a zero code never matches
    always_comb begin
        active = (r_phase != PH_IDLE) && (r_phase != PH_DONE);
        cur    = r_phase - PW'(1);
        for (int k = 0; k < NUM_KEYS; k++) begin
            hit[k]     = (r_key_codes[k] != '0) && (i_in.frame_code == r_key_codes[k]);
            cur_sel[k] = (cur == PW'(k));
        end
        // lowest matching key wins
        first_hit = hit & (~hit + NUM_KEYS'(1));
        dup_hit   = |(hit & ~cur_sel);
        frame_ok  = (i_in.frame_code != '0) && (i_in.frame_code != ikm_pkg::IGNORED_CODE)
                    && !(i_in.frame_bad && !active);
        code_sel  = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (32'(i_in.arg) == k) begin
                code_sel = r_key_codes[k];
            end
        end
    end

    // next-state logic for one beat
    always_comb begin
        n_key_codes = r_key_codes;
        n_flag_bits = r_flag_bits;
        n_hold_cnt  = r_hold_cnt;
        n_guard_cnt = r_guard_cnt;
        n_recent    = r_recent;
        n_phase     = r_phase;
        n_walk_all  = r_walk_all;
        n_dup       = r_dup;
        n_shield    = r_shield;

        unique case (i_in.kind)
            ikm_pkg::KIND_FRAME: begin
                if (frame_ok) begin
                    n_recent = i_in.frame_code;
                    if (active) begin
                        // learn only after the guard interval
                        if (r_guard_cnt > {1'b0, r_guard_ticks}) begin
                            n_guard_cnt = '0;
                            if (dup_hit) begin
                                n_dup = 1'b1;
                            end else begin
                                n_dup = 1'b0;
                                for (int k = 0; k < NUM_KEYS; k++) begin
                                    if (cur_sel[k]) begin
                                        n_key_codes[k] = i_in.frame_code;
                                    end
                                end
                                if (r_walk_all && (32'(cur) + 1 < NUM_KEYS)) begin
                                    n_phase = cur + PW'(2);
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                    end else if (!r_shield) begin
                        for (int k = 0; k < NUM_KEYS; k++) begin
                            if (first_hit[k]) begin
                                n_flag_bits[k] = 1'b1;
                                n_hold_cnt[k]  = r_hold_ticks;
                            end
                        end
                    end
                end
            end
            ikm_pkg::KIND_TICK: begin
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (r_hold_cnt[k] == '0) begin
                        n_flag_bits[k] = 1'b0;
                    end else begin
                        n_hold_cnt[k] = r_hold_cnt[k] - ikm_pkg::HOLD_W'(1);
                    end
                end
                if (r_guard_cnt != ikm_pkg::GUARD_MAX) begin
                    n_guard_cnt = r_guard_cnt + ikm_pkg::GUARD_W'(1);
                end
            end
            ikm_pkg::KIND_LEARN_ONE: begin
                if (32'(i_in.arg) < NUM_KEYS) begin
                    n_walk_all  = 1'b0;
                    n_dup       = 1'b0;
                    n_phase     = PW'(i_in.arg) + PW'(1);
                    n_guard_cnt = '0;
                end
            end
            ikm_pkg::KIND_LEARN_ALL: begin
                n_walk_all  = 1'b1;
                n_dup       = 1'b0;
                n_phase     = PW'(1);
                n_guard_cnt = '0;
            end
            ikm_pkg::KIND_CANCEL: begin
                n_phase    = PH_IDLE;
                n_walk_all = 1'b0;
                n_dup      = 1'b0;
            end
            ikm_pkg::KIND_SHIELD: begin
                n_shield = i_in.arg[0];
                // dropping the shield also ends learning
                if (!i_in.arg[0]) begin
                    n_phase = PH_IDLE;
                end
            end
            ikm_pkg::KIND_CONSUME: begin
                if (!r_shield && !active) begin
                    for (int k = 0; k < NUM_KEYS; k++) begin
                        if ((k == ikm_pkg::KEY_STANDBY && i_in.arg == ikm_pkg::ARG_STANDBY)
                            || (k == ikm_pkg::KEY_POWEROFF
                                && i_in.arg == ikm_pkg::ARG_POWEROFF)) begin
                            n_flag_bits[k] = 1'b0;
                        end
                    end
                end
            end
            ikm_pkg::KIND_CLR_LAST: n_recent = '0;
            ikm_pkg::KIND_CLR_ERR:  n_dup    = 1'b0;
            default: ;
        endcase
    end

    // flags are hidden while shielded or learning
    always_comb begin
        n_active  = (n_phase != PH_IDLE) && (n_phase != PH_DONE);
        flags_vis = '0;
        if (!n_shield && !n_active) begin
            flags_vis = ikm_pkg::FLAGS_W'(n_flag_bits[FW-1:0]);
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_key_codes[k] <= ikm_pkg::preset_code(k);
                r_hold_cnt[k]  <= '0;
            end
            r_flag_bits <= '0;
            r_guard_cnt <= '0;
            r_recent    <= '0;
            r_phase     <= PH_IDLE;
            r_walk_all  <= 1'b0;
            r_dup       <= 1'b0;
            r_shield    <= 1'b0;
        end else if (in_fire) begin
            r_key_codes <= n_key_codes;
            r_hold_cnt  <= n_hold_cnt;
            r_flag_bits <= n_flag_bits;
            r_guard_cnt <= n_guard_cnt;
            r_recent    <= n_recent;
            r_phase     <= n_phase;
            r_walk_all  <= n_walk_all;
            r_dup       <= n_dup;
            r_shield    <= n_shield;
        end
    end

    // result register, valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register, payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_key_flags   <= flags_vis;
            r_last_code   <= n_recent;
            r_learn_state <= ikm_pkg::STATE_W'(n_phase);
            r_learn_seq   <= n_walk_all;
            r_dup_err     <= n_dup;
            r_code_out    <= (i_in.kind == ikm_pkg::KIND_READ) ? code_sel : '0;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.key_flags        = r_key_flags;
    assign o_out.last_code        = r_last_code;
    assign o_out.learn_state      = r_learn_state;
    assign o_out.learn_sequential = r_learn_seq;
    assign o_out.duplicate_error  = r_dup_err;
    assign o_out.code_out         = r_code_out;

endmodule

`default_nettype wire

@@ hdl/ikm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "ir_key_mapper_with_learning_macros.svh"

module ikm_checker #(
    parameter int NUM_KEYS = ikm_pkg::NUM_KEYS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [ikm_pkg::FLAGS_W-1:0]   i_key_flags,
    input wire logic [ikm_pkg::CODE_W-1:0]    i_last_code,
    input wire logic [ikm_pkg::STATE_W-1:0]   i_learn_state,
    input wire logic                          i_learn_sequential,
    input wire logic                          i_duplicate_error,
    input wire logic [ikm_pkg::CODE_W-1:0]    i_code_out
);

    localparam logic [ikm_pkg::STATE_W-1:0] LS_DONE = ikm_pkg::STATE_W'(NUM_KEYS + 1);
    localparam logic                        LS_UNIQUE = (NUM_KEYS < 15);

    // stalled result beat holds
    `IKM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_key_flags) && $stable(i_last_code) && $stable(i_learn_state) && $stable(i_learn_sequential) && $stable(i_duplicate_error) && $stable(i_code_out))

    // every accepted beat yields a result in the next cycle
    `IKM_ASSERT_NEXT(a_one_result, i_in_valid && i_in_ready, i_out_valid)

    // result register is empty after reset
    `IKM_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !i_out_valid)

    // no key flags while a key is being learned
    `IKM_ASSERT_SAME(a_flags_learning, i_out_valid && LS_UNIQUE && i_learn_state != '0 && i_learn_state != LS_DONE, i_key_flags == '0)

endmodule

bind ir_key_mapper_with_learning ikm_checker #(
    .NUM_KEYS(NUM_KEYS)
) u_ikm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_key_flags        (o_out.key_flags),
    .i_last_code        (o_out.last_code),
    .i_learn_state      (o_out.learn_state),
    .i_learn_sequential (o_out.learn_sequential),
    .i_duplicate_error  (o_out.duplicate_error),
    .i_code_out         (o_out.code_out)
);

`default_nettype wire
